// ----- rtl/tcp_cubic_window_control_defines.svh -----
// Assertion helpers for the checks in the top module.
`ifndef TCP_CUBIC_WINDOW_CONTROL_DEFINES_SVH
`define TCP_CUBIC_WINDOW_CONTROL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcw check failed (same cycle)");

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcw check failed (next cycle)");

`endif

// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

   // Event kind of one request.
   typedef enum logic {
      EV_ACK  = 1'b0,
      EV_LOSS = 1'b1
   } event_kind_type;

   // One classified request as it waits between front and back.
   typedef struct packed {
      event_kind_type kind;
      logic [31:0]    ack_seq;
      logic [31:0]    now_ms;
      logic [15:0]    smoothed_rtt;
   } item_type;

   // One register write from the configuration channel.
   typedef struct packed {
      logic        valid;
      logic [1:0]  index;
      logic [31:0] data;
   } csr_write_type;

   // Status of the back engine.
   typedef struct packed {
      logic busy;
      logic rsp_load;
   } back_status_type;

   // Sequencer steps of the back engine.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOSS,
      ST_ROUND,
      ST_HYST,
      ST_GROW,
      ST_CA_PREP,
      ST_EPOCH,
      ST_CBRT,
      ST_TIME,
      ST_SQUARE,
      ST_CUBE,
      ST_DELTA,
      ST_TARGET,
      ST_DIV_CNT,
      ST_RENO,
      ST_DIV_RENO,
      ST_INC,
      ST_DONE
   } back_state_type;

   // Register indexes.
   localparam logic [1:0] CSR_INIT_WINDOW   = 2'd0;
   localparam logic [1:0] CSR_INIT_THRESH   = 2'd1;
   localparam logic [1:0] CSR_HS_SAMPLES    = 2'd2;
   localparam logic [1:0] CSR_HS_LOW_WINDOW = 2'd3;

   // HyStart exit reasons.
   localparam logic [1:0] HS_NONE  = 2'd0;
   localparam logic [1:0] HS_TRAIN = 2'd1;
   localparam logic [1:0] HS_DELAY = 2'd2;

   // Arithmetic constants.
   localparam logic [30:0] THRESH_MAX        = 31'h7FFF_FFFF;
   localparam logic [31:0] CUBE_FACTOR       = 32'd2681735677;
   localparam logic [8:0]  RTT_SCALE         = 9'd410;
   localparam logic [9:0]  BETA_NUM          = 10'd819;
   localparam logic [10:0] BETA_FC           = 11'd1843;
   localparam logic [15:0] RTT_DEFAULT       = 16'd100;
   localparam logic [31:0] ACK_TRAIN_GAP     = 32'd2;
   localparam logic [6:0]  FLAT_ACK_SCALE    = 7'd100;
   localparam logic [23:0] INIT_WINDOW_RESET = 24'd10;
   localparam logic [31:0] COUNT_MAX         = 32'hFFFF_FFFF;

   // Cube root unit geometry.
   localparam int CBRT_IN_BITS   = 63;
   localparam int CBRT_ROOT_BITS = 21;
   localparam int CBRT_STEPS     = 22;

endpackage

// ----- rtl/tcw_front.sv -----
module tcw_front
   import tcw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        cmd,
   input  logic [31:0] ack_seq,
   input  logic [31:0] now_ms,
   input  logic [15:0] smoothed_rtt,
   output logic        full,
   output logic        item_valid,
   output item_type    item,
   input  logic        item_pop
);

   localparam int DEPTH = 2;
   localparam int PW    = $clog2(DEPTH);

   item_type         slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;
   item_type         new_item;

   // Classify the incoming request.
   always_comb begin
      new_item.kind         = cmd ? EV_LOSS : EV_ACK;
      new_item.ack_seq      = ack_seq;
      new_item.now_ms       = now_ms;
      new_item.smoothed_rtt = smoothed_rtt;
   end

   assign full       = (count_ff == (PW+1)'(DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push_ok    = push && !full;
   assign pop_ok     = item_pop && item_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (!push_ok && pop_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ----- rtl/tcw_cbrt.sv -----
module tcw_cbrt
   import tcw_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [CBRT_IN_BITS-1:0]   x,
   output logic                      done,
   output logic [CBRT_ROOT_BITS-1:0] root
);

   localparam int IW = $clog2(CBRT_STEPS);
   localparam int BW = 2 * CBRT_ROOT_BITS + 2;

   logic                      busy_ff, busy_in;
   logic                      phase_ff, phase_in;
   logic                      done_ff, done_in;
   logic [IW-1:0]             iter_ff, iter_in;
   logic [CBRT_IN_BITS-1:0]   x_ff, x_in;
   logic [CBRT_ROOT_BITS-1:0] y_ff, y_in;
   logic [BW-1:0]             b_ff, b_in;
   logic [CBRT_ROOT_BITS-1:0] y_sh;
   logic [BW-1:0]             yy;
   logic [5:0]                shamt;
   logic [CBRT_IN_BITS-1:0]   x_top;
   logic [CBRT_IN_BITS-1:0]   b_wide;
   logic [CBRT_IN_BITS-1:0]   b_shift;
   logic                      take;

   assign done = done_ff;
   assign root = y_ff;

   // Digit step: one phase forms 3y(y+1)+1, the next compares and subtracts.
   always_comb begin
      y_sh    = y_ff << 1;
      yy      = BW'(y_sh) * BW'(y_sh + 1'b1);
      shamt   = 6'(iter_ff) * 6'd3;
      x_top   = x_ff >> shamt;
      b_wide  = CBRT_IN_BITS'(b_ff);
      b_shift = b_wide << shamt;
      take    = (x_top >= b_wide);

      busy_in  = busy_ff;
      phase_in = phase_ff;
      iter_in  = iter_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      b_in     = b_ff;
      done_in  = 1'b0;

      if (start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         iter_in  = IW'(CBRT_STEPS - 1);
         x_in     = x;
         y_in     = '0;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            y_in     = y_sh;
            b_in     = (yy << 1) + yy + 1'b1;
            phase_in = 1'b1;
         end else begin
            if (take) begin
               x_in = x_ff - b_shift;
               y_in = y_ff + 1'b1;
            end
            phase_in = 1'b0;
            if (iter_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               iter_in = iter_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      b_ff    <= b_in;
   end

endmodule

// ----- rtl/tcw_div.sv -----
module tcw_div #(
   parameter int NUM_BITS = 24,
   parameter int DEN_BITS = 33
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic                done,
   output logic [NUM_BITS-1:0] quot
);

   localparam int CW = $clog2(NUM_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS:0]   trial;
   logic [DEN_BITS:0]   trial_sub;
   logic                ge;

   assign done = done_ff;
   assign quot = num_ff;

   // Restoring division, one quotient bit a cycle.
   always_comb begin
      trial     = {rem_ff, num_ff[NUM_BITS-1]};
      trial_sub = trial - {1'b0, den_ff};
      ge        = (trial >= {1'b0, den_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NUM_BITS);
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? trial_sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         num_in = {num_ff[NUM_BITS-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

endmodule

// ----- rtl/tcw_back.sv -----
module tcw_back
   import tcw_pkg::*;
#(
   parameter int WINDOW_BITS = 24
) (
   input  logic            clock,
   input  logic            reset,
   input  csr_write_type   csr,
   input  logic            item_valid,
   input  item_type        item,
   output logic            item_pop,
   input  logic            rsp_pop,
   output logic            rsp_valid,
   output logic [23:0]     rsp_cwnd,
   output logic [30:0]     rsp_ssthresh,
   output back_status_type status
);

   localparam int         W        = WINDOW_BITS;
   localparam int         DEN_BITS = 33;
   localparam logic [W-1:0] WMAX   = '1;

   back_state_type state_ff, state_in;

   // Connection state.
   logic [W-1:0]  window_ff, window_in;
   logic [30:0]   thresh_ff, thresh_in;
   logic [W-1:0]  lmax_ff, lmax_in;
   logic [31:0]   epoch_ff, epoch_in;
   logic [W-1:0]  origin_ff, origin_in;
   logic [15:0]   min_delay_ff, min_delay_in;
   logic [W-1:0]  reno_ff, reno_in;
   logic [CBRT_ROOT_BITS-1:0] plateau_ff, plateau_in;
   logic [31:0]   apk_ff, apk_in;
   logic [31:0]   tally_ff, tally_in;
   logic [1:0]    hs_found_ff, hs_found_in;
   logic [7:0]    hs_left_ff, hs_left_in;
   logic [31:0]   hs_start_ff, hs_start_in;
   logic [31:0]   hs_last_ff, hs_last_in;
   logic [15:0]   hs_prev_ff, hs_prev_in;
   logic [15:0]   hs_rtt_ff, hs_rtt_in;
   logic [15:0]   hs_min_ff, hs_min_in;
   logic [31:0]   hs_end_ff, hs_end_in;
   logic [7:0]    samples_ff, samples_in;
   logic [23:0]   low_win_ff, low_win_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Per-request working registers.
   item_type      cur_ff, cur_in;
   logic          lt_ff, lt_in;
   logic          big_ff, big_in;
   logic [CBRT_ROOT_BITS-1:0] off_ff, off_in;
   logic [41:0]   sq_ff, sq_in;
   logic [62:0]   cube_ff, cube_in;
   logic [30:0]   delta_ff, delta_in;
   logic [23:0]   rsp_cwnd_ff, rsp_cwnd_in;
   logic [30:0]   rsp_ssthresh_ff, rsp_ssthresh_in;

   // Arithmetic units; the divider is shared by both divisions.
   logic                      cbrt_start, cbrt_done;
   logic [CBRT_IN_BITS-1:0]   cbrt_x;
   logic [CBRT_ROOT_BITS-1:0] cbrt_root;
   logic                      div_start, div_done;
   logic [DEN_BITS-1:0]       div_den;
   logic [W-1:0]              div_quot;
   logic                      rsp_load;

   // Derived values.
   logic [31:0]   w32;
   logic [W-1:0]  win_inc;
   logic [W+10:0] loss_fc_prod;
   logic [W+9:0]  loss_beta_prod;
   logic [W-1:0]  loss_win;
   logic [15:0]   rtt;
   logic [15:0]   dmin;
   logic          hs_active;
   logic          train;
   logic          since_ok;
   logic [15:0]   rr_new;
   logic [7:0]    left_new;
   logic [16:0]   n_raw;
   logic [16:0]   n_step;
   logic [16:0]   prev_plus;
   logic          delay_hit;
   logic [1:0]    found_new;
   logic          set_thr;
   logic [15:0]   md_new;
   logic [W+2:0]  p5;
   logic [W:0]    q54;
   logic [W-1:0]  lmax_init;
   logic [31:0]   t32;
   logic [33:0]   diff34;
   logic [33:0]   mag34;
   logic [71:0]   scaled;
   logic [31:0]   v32;
   logic [33:0]   tgt34;
   logic [33:0]   tgt_gap;
   logic          tgt_gt;
   logic [39:0]   w100;
   logic [31:0]   w100_sat;
   logic [31:0]   mc32;
   logic [31:0]   cw_ext;

   tcw_cbrt u_cbrt (
      .clock (clock),
      .reset (reset),
      .start (cbrt_start),
      .x     (cbrt_x),
      .done  (cbrt_done),
      .root  (cbrt_root)
   );

   tcw_div #(
      .NUM_BITS (W),
      .DEN_BITS (DEN_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (window_ff),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cwnd     = rsp_cwnd_ff;
   assign rsp_ssthresh = rsp_ssthresh_ff;
   assign status.busy     = (state_ff != ST_IDLE);
   assign status.rsp_load = rsp_load;

   // Window helpers and the loss decrease.
   always_comb begin
      w32            = 32'(window_ff);
      win_inc        = (window_ff == WMAX) ? window_ff : window_ff + 1'b1;
      loss_fc_prod   = (W+11)'(window_ff) * (W+11)'(BETA_FC);
      loss_beta_prod = (W+10)'(window_ff) * (W+10)'(BETA_NUM);
      loss_win       = loss_beta_prod[W+9:10];
      cw_ext         = 32'(csr.data[23:0]);
   end

   // HyStart round checks.
   always_comb begin
      rtt       = (cur_ff.smoothed_rtt != '0) ? cur_ff.smoothed_rtt : RTT_DEFAULT;
      dmin      = (hs_min_ff == '0) ? rtt : ((hs_min_ff < rtt) ? hs_min_ff : rtt);
      hs_active = (hs_found_ff == HS_NONE) && (w32 <= 32'(thresh_ff));
      train     = ((cur_ff.now_ms - hs_last_ff) <= ACK_TRAIN_GAP);
      since_ok  = ((cur_ff.now_ms - hs_start_ff) >= 32'(dmin >> 1));
      rr_new    = hs_rtt_ff;
      left_new  = hs_left_ff;
      if (hs_left_ff != '0) begin
         rr_new   = (hs_rtt_ff == '0 || rtt < hs_rtt_ff) ? rtt : hs_rtt_ff;
         left_new = hs_left_ff - 1'b1;
      end
      n_raw     = (17'(hs_prev_ff) + 17'd15) >> 4;
      n_step    = (n_raw < 17'd2) ? 17'd2 : n_raw;
      prev_plus = 17'(hs_prev_ff) + n_step;
      delay_hit = (left_new == '0) && (17'(rr_new) >= prev_plus);
      if (delay_hit) begin
         found_new = HS_DELAY;
      end else if (train && since_ok) begin
         found_new = HS_TRAIN;
      end else begin
         found_new = HS_NONE;
      end
      set_thr = (found_new != HS_NONE) && (w32 >= 32'(low_win_ff));
   end

   // Cubic target arithmetic.
   always_comb begin
      md_new    = (min_delay_ff != '0 && min_delay_ff < cur_ff.smoothed_rtt) ?
                  min_delay_ff : cur_ff.smoothed_rtt;
      p5        = (W+3)'(window_ff) * (W+3)'(5);
      q54       = p5[W+2:2];
      lmax_init = q54[W] ? WMAX : q54[W-1:0];
      cbrt_x    = CBRT_IN_BITS'(CUBE_FACTOR) * CBRT_IN_BITS'(lmax_ff - window_ff);
      t32       = cur_ff.now_ms + 32'(min_delay_ff) - epoch_ff;
      diff34    = {{2{t32[31]}}, t32} - 34'(plateau_ff);
      mag34     = diff34[33] ? (34'd0 - diff34) : diff34;
      scaled    = 72'(cube_ff) * 72'(RTT_SCALE);
      v32       = scaled[71:40];
      tgt34     = lt_ff ? (34'(origin_ff) - 34'(delta_ff)) : (34'(origin_ff) + 34'(delta_ff));
      tgt_gt    = ($signed(tgt34) > $signed(34'(window_ff)));
      tgt_gap   = tgt34 - 34'(window_ff);
      w100      = 40'(window_ff) * 40'(FLAT_ACK_SCALE);
      w100_sat  = (w100[39:32] != '0) ? COUNT_MAX : w100[31:0];
      mc32      = 32'(div_quot);
   end

   // Sequencer: next state and next values.
   always_comb begin
      state_in        = state_ff;
      window_in       = window_ff;
      thresh_in       = thresh_ff;
      lmax_in         = lmax_ff;
      epoch_in        = epoch_ff;
      origin_in       = origin_ff;
      min_delay_in    = min_delay_ff;
      reno_in         = reno_ff;
      plateau_in      = plateau_ff;
      apk_in          = apk_ff;
      tally_in        = tally_ff;
      hs_found_in     = hs_found_ff;
      hs_left_in      = hs_left_ff;
      hs_start_in     = hs_start_ff;
      hs_last_in      = hs_last_ff;
      hs_prev_in      = hs_prev_ff;
      hs_rtt_in       = hs_rtt_ff;
      hs_min_in       = hs_min_ff;
      hs_end_in       = hs_end_ff;
      samples_in      = samples_ff;
      low_win_in      = low_win_ff;
      cur_in          = cur_ff;
      lt_in           = lt_ff;
      big_in          = big_ff;
      off_in          = off_ff;
      sq_in           = sq_ff;
      cube_in         = cube_ff;
      delta_in        = delta_ff;
      rsp_cwnd_in     = rsp_cwnd_ff;
      rsp_ssthresh_in = rsp_ssthresh_ff;
      item_pop        = 1'b0;
      cbrt_start      = 1'b0;
      div_start       = 1'b0;
      div_den         = '0;
      rsp_load        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               cur_in   = item;
               state_in = (item.kind == EV_LOSS) ? ST_LOSS : ST_ROUND;
            end
         end
         ST_LOSS: begin
            epoch_in  = '0;
            lmax_in   = (window_ff < lmax_ff) ? loss_fc_prod[W+10:11] : window_ff;
            window_in = loss_win;
            thresh_in = 31'(loss_win);
            state_in  = ST_DONE;
         end
         ST_ROUND: begin
            // A new round begins once the ack reaches or passes the round's end sequence.
            if ($signed(cur_ff.ack_seq) >= $signed(hs_end_ff)) begin
               hs_start_in = cur_ff.now_ms;
               hs_last_in  = cur_ff.now_ms;
               hs_prev_in  = hs_rtt_ff;
               hs_rtt_in   = '0;
               hs_left_in  = samples_ff;
               hs_end_in   = cur_ff.ack_seq;
            end
            state_in = ST_HYST;
         end
         ST_HYST: begin
            if (hs_min_ff == '0) begin
               hs_min_in = rtt;
            end
            if (hs_active) begin
               if (train) begin
                  hs_last_in = cur_ff.now_ms;
               end
               hs_rtt_in  = rr_new;
               hs_left_in = left_new;
               if (found_new != HS_NONE) begin
                  hs_found_in = found_new;
               end
               if (set_thr) begin
                  thresh_in = 31'(window_ff);
               end
            end
            state_in = ST_GROW;
         end
         ST_GROW: begin
            if (w32 <= 32'(thresh_ff)) begin
               window_in = win_inc;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_CA_PREP;
            end
         end
         ST_CA_PREP: begin
            min_delay_in = md_new;
            if (lmax_ff == '0) begin
               lmax_in = lmax_init;
            end
            state_in = ST_EPOCH;
         end
         ST_EPOCH: begin
            state_in = ST_TIME;
            if (epoch_ff == '0) begin
               epoch_in = cur_ff.now_ms;
               reno_in  = window_ff;
               if (window_ff < lmax_ff) begin
                  origin_in  = lmax_ff;
                  cbrt_start = 1'b1;
                  state_in   = ST_CBRT;
               end else begin
                  origin_in  = window_ff;
                  plateau_in = '0;
               end
            end
         end
         ST_CBRT: begin
            if (cbrt_done) begin
               plateau_in = cbrt_root;
               state_in   = ST_TIME;
            end
         end
         ST_TIME: begin
            lt_in    = diff34[33];
            big_in   = (mag34[33:CBRT_ROOT_BITS] != '0);
            off_in   = mag34[CBRT_ROOT_BITS-1:0];
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            sq_in    = 42'(off_ff) * 42'(off_ff);
            state_in = ST_CUBE;
         end
         ST_CUBE: begin
            cube_in  = 63'(sq_ff) * 63'(off_ff);
            state_in = ST_DELTA;
         end
         ST_DELTA: begin
            delta_in = (big_ff || v32[31]) ? THRESH_MAX : v32[30:0];
            state_in = ST_TARGET;
         end
         ST_TARGET: begin
            if (tgt_gt) begin
               div_start = 1'b1;
               div_den   = tgt_gap[DEN_BITS-1:0];
               state_in  = ST_DIV_CNT;
            end else begin
               apk_in   = w100_sat;
               state_in = ST_RENO;
            end
         end
         ST_DIV_CNT: begin
            if (div_done) begin
               apk_in   = mc32;
               state_in = ST_RENO;
            end
         end
         ST_RENO: begin
            if (reno_ff > window_ff) begin
               div_start = 1'b1;
               div_den   = DEN_BITS'(reno_ff - window_ff);
               state_in  = ST_DIV_RENO;
            end else begin
               state_in = ST_INC;
            end
         end
         ST_DIV_RENO: begin
            if (div_done) begin
               if (apk_ff > mc32) begin
                  apk_in = mc32;
               end
               state_in = ST_INC;
            end
         end
         ST_INC: begin
            if (tally_ff > apk_ff) begin
               window_in = win_inc;
               tally_in  = '0;
            end else if (tally_ff != COUNT_MAX) begin
               tally_in = tally_ff + 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_load        = 1'b1;
               rsp_cwnd_in     = 24'(window_ff);
               rsp_ssthresh_in = thresh_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Result register: loaded by the engine, drained by pop.
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      // Register writes must arrive only while the engine is idle; the block does not enforce it.
      if (csr.valid) begin
         unique case (csr.index)
            CSR_INIT_WINDOW: begin
               window_in = (cw_ext > 32'(WMAX)) ? WMAX : cw_ext[W-1:0];
            end
            CSR_INIT_THRESH: begin
               thresh_in = (csr.data[30:0] != '0) ? csr.data[30:0] : THRESH_MAX;
            end
            CSR_HS_SAMPLES: begin
               samples_in = csr.data[7:0];
            end
            CSR_HS_LOW_WINDOW: begin
               low_win_in = csr.data[23:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= W'(INIT_WINDOW_RESET);
         thresh_ff    <= THRESH_MAX;
         lmax_ff      <= '0;
         epoch_ff     <= '0;
         origin_ff    <= '0;
         min_delay_ff <= '0;
         reno_ff      <= '0;
         plateau_ff   <= '0;
         apk_ff       <= '0;
         tally_ff     <= '0;
         hs_found_ff  <= HS_NONE;
         hs_left_ff   <= '0;
         hs_start_ff  <= '0;
         hs_last_ff   <= '0;
         hs_prev_ff   <= '0;
         hs_rtt_ff    <= '0;
         hs_min_ff    <= '0;
         hs_end_ff    <= '0;
         samples_ff   <= '0;
         low_win_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         thresh_ff    <= thresh_in;
         lmax_ff      <= lmax_in;
         epoch_ff     <= epoch_in;
         origin_ff    <= origin_in;
         min_delay_ff <= min_delay_in;
         reno_ff      <= reno_in;
         plateau_ff   <= plateau_in;
         apk_ff       <= apk_in;
         tally_ff     <= tally_in;
         hs_found_ff  <= hs_found_in;
         hs_left_ff   <= hs_left_in;
         hs_start_ff  <= hs_start_in;
         hs_last_ff   <= hs_last_in;
         hs_prev_ff   <= hs_prev_in;
         hs_rtt_ff    <= hs_rtt_in;
         hs_min_ff    <= hs_min_in;
         hs_end_ff    <= hs_end_in;
         samples_ff   <= samples_in;
         low_win_ff   <= low_win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff          <= cur_in;
      lt_ff           <= lt_in;
      big_ff          <= big_in;
      off_ff          <= off_in;
      sq_ff           <= sq_in;
      cube_ff         <= cube_in;
      delta_ff        <= delta_in;
      rsp_cwnd_ff     <= rsp_cwnd_in;
      rsp_ssthresh_ff <= rsp_ssthresh_in;
   end

endmodule

// ----- rtl/tcp_cubic_window_control.sv -----
// Channel   Direction  Handshake            Payload
// req       in         push / full          req_cmd, req_ack_seq, req_now_ms, req_smoothed_rtt
// rsp       out        empty / pop          rsp_cwnd, rsp_ssthresh
// csr       in         csr_valid/csr_ready  csr_index, csr_wdata
//
// A loss request runs the loss and done steps; a slow start ack runs the round,
// HyStart, grow and done steps. A congestion avoidance ack may also wait on the
// serial divider, and one that opens a new epoch below the last maximum on the cube root.
// A two-entry request queue lets the front accept while the back engine works.
// Reset is synchronous and active high; no clearing pass follows it.
`include "tcp_cubic_window_control_defines.svh"

module tcp_cubic_window_control
   import tcw_pkg::*;
#(
   parameter int WINDOW_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_cmd,
   input  logic [31:0] req_ack_seq,
   input  logic [31:0] req_now_ms,
   input  logic [15:0] req_smoothed_rtt,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [23:0] rsp_cwnd,
   output logic [30:0] rsp_ssthresh,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   item_type        item;
   logic            item_valid;
   logic            item_pop;
   logic            rsp_valid;
   csr_write_type   csr_wr;
   back_status_type status;

   // Register writes are always taken.
   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_wdata;
   assign rsp_empty    = !rsp_valid;

   tcw_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push),
      .cmd          (req_cmd),
      .ack_seq      (req_ack_seq),
      .now_ms       (req_now_ms),
      .smoothed_rtt (req_smoothed_rtt),
      .full         (req_full),
      .item_valid   (item_valid),
      .item         (item),
      .item_pop     (item_pop)
   );

   tcw_back #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .csr          (csr_wr),
      .item_valid   (item_valid),
      .item         (item),
      .item_pop     (item_pop),
      .rsp_pop      (rsp_pop),
      .rsp_valid    (rsp_valid),
      .rsp_cwnd     (rsp_cwnd),
      .rsp_ssthresh (rsp_ssthresh),
      .status       (status)
   );

   // The engine takes a request only from a non-empty queue and only when idle.
   `TCW_ASSERT_NOW(a_pop_has_item, clock, reset, item_pop, item_valid)
   `TCW_ASSERT_NOW(a_pop_when_idle, clock, reset, item_pop, !status.busy)
   // An accepted request is waiting in the queue on the next cycle.
   `TCW_ASSERT_NEXT(a_push_lands, clock, reset, req_push && !req_full, item_valid)
   // A taken result with no new one behind it leaves the result side empty.
   `TCW_ASSERT_NEXT(a_pop_drains, clock, reset, rsp_pop && !rsp_empty && !status.rsp_load,
                    rsp_empty)

endmodule

// ----- bench/tcp_cubic_window_control_tb.sv -----
`timescale 1ns / 100ps

module tcp_cubic_window_control_tb;
   import tcw_pkg::*;

   localparam logic [23:0] WIN_MAX = 24'hFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_cmd = 1'b0;
   logic [31:0] req_ack_seq = '0;
   logic [31:0] req_now_ms = '0;
   logic [15:0] req_smoothed_rtt = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [23:0] rsp_cwnd;
   logic [30:0] rsp_ssthresh;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   tcp_cubic_window_control dut (.*);

   always #1 clock = ~clock;

   // Expected window and threshold for each accepted request, oldest first.
   typedef struct {
      logic [23:0] cwnd;
      logic [30:0] ssthresh;
   } window_pair_type;

   window_pair_type expected_windows[$];

   int  error_count = 0;
   int  cycle_count = 0;
   bit  pop_steady = 1'b0;
   bit  push_steady = 1'b0;
   int  pop_idle_pct = 32;

   // Predictor state.
   logic [23:0] p_init_window;
   logic [30:0] p_init_thresh;
   logic [7:0]  p_hs_samples;
   logic [23:0] p_hs_low;
   logic [31:0] p_window, p_thresh, p_last_max, p_epoch, p_origin, p_min_delay;
   logic [31:0] p_reno, p_plateau, p_ack_tally, p_acks_per_inc, p_inc_tally;
   logic [1:0]  p_hs_found;
   logic [31:0] p_hs_left, p_hs_round_start, p_hs_last_ack, p_hs_prev_rtt;
   logic [31:0] p_hs_round_rtt, p_hs_min_delay, p_hs_end_seq;

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1500000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [31:0] sat_window(logic [63:0] v);
      return (v > WIN_MAX) ? {8'd0, WIN_MAX} : v[31:0];
   endfunction

   function automatic logic [31:0] sat_count(logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic logic [31:0] cube_root(logic [63:0] x);
      logic [63:0] y;
      logic [63:0] b;
      y = 0;
      for (int s = 63; s >= 0; s -= 3) begin
         y = y << 1;
         b = 3 * y * (y + 1) + 1;
         if ((x >> s) >= b) begin
            x = x - (b << s);
            y = y + 1;
         end
      end
      return y[31:0];
   endfunction

   function automatic logic [31:0] cubic_growth(logic [63:0] off);
      logic [63:0] c, v;
      if (off >= 64'd2097152) return 32'h7FFF_FFFF;
      c = off * off * off;
      v = 64'd410 * (c >> 40) + ((64'd410 * {24'd0, c[39:0]}) >> 40);
      return (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
   endfunction

   task automatic reset_predictor();
      p_init_window = INIT_WINDOW_RESET;
      p_init_thresh = '0;
      p_hs_samples = '0;
      p_hs_low = '0;
      p_window = {8'd0, INIT_WINDOW_RESET};
      p_thresh = {1'b0, THRESH_MAX};
      {p_last_max, p_epoch, p_origin, p_min_delay, p_reno, p_plateau} = '0;
      {p_ack_tally, p_acks_per_inc, p_inc_tally, p_hs_left} = '0;
      p_hs_found = HS_NONE;
      {p_hs_round_start, p_hs_last_ack, p_hs_prev_rtt, p_hs_round_rtt} = '0;
      {p_hs_min_delay, p_hs_end_seq} = '0;
   endtask

   task automatic apply_register(logic [1:0] index, logic [31:0] value);
      case (index)
         CSR_INIT_WINDOW: begin
            p_init_window = value[23:0];
            p_window = {8'd0, value[23:0]};
         end
         CSR_INIT_THRESH: begin
            p_init_thresh = value[30:0];
            p_thresh = (value[30:0] != 0) ? {1'b0, value[30:0]} : {1'b0, THRESH_MAX};
         end
         CSR_HS_SAMPLES: p_hs_samples = value[7:0];
         default: p_hs_low = value[23:0];
      endcase
   endtask

   // HyStart slow-start exit checks.
   task automatic hystart_step(logic [31:0] now, logic [15:0] srtt);
      logic [31:0] rtt, dmin, n;
      rtt = (srtt != 0) ? {16'd0, srtt} : {16'd0, RTT_DEFAULT};
      dmin = (p_hs_min_delay < rtt) ? p_hs_min_delay : rtt;
      if (p_hs_min_delay == 0) begin
         dmin = rtt;
         p_hs_min_delay = rtt;
      end
      if (p_hs_found != HS_NONE || p_window > p_thresh) return;
      if (now - p_hs_last_ack <= ACK_TRAIN_GAP) begin
         p_hs_last_ack = now;
         if (now - p_hs_round_start >= dmin / 2) p_hs_found = HS_TRAIN;
      end
      if (p_hs_left != 0) begin
         if (rtt < p_hs_round_rtt) p_hs_round_rtt = rtt;
         if (p_hs_round_rtt == 0) p_hs_round_rtt = rtt;
         p_hs_left = p_hs_left - 1;
      end
      n = (p_hs_prev_rtt + 15) >> 4;
      if (n < 2) n = 2;
      if (p_hs_left == 0 && {32'd0, p_hs_round_rtt} >= {32'd0, p_hs_prev_rtt} + n)
         p_hs_found = HS_DELAY;
      if (p_hs_found != HS_NONE && p_window >= {8'd0, p_hs_low}) p_thresh = p_window;
   endtask

   // Congestion avoidance: cubic target and TCP-friendly estimate.
   task automatic cubic_step(logic [31:0] now, logic [15:0] srtt);
      logic [31:0] w, step, d, mc, rtt;
      logic signed [63:0] t, target;
      logic [63:0] off, cnt;
      w = p_window;
      rtt = {16'd0, srtt};
      p_min_delay = (p_min_delay != 0 && p_min_delay < rtt) ? p_min_delay : rtt;
      p_ack_tally = sat_count({32'd0, p_ack_tally} + 1);
      if (p_last_max == 0) p_last_max = sat_window({32'd0, w} * 5 / 4);
      if (p_epoch == 0) begin
         p_epoch = now;
         if (w < p_last_max) begin
            p_plateau = cube_root({32'd0, CUBE_FACTOR} * {32'd0, p_last_max - w});
            p_origin = p_last_max;
         end else begin
            p_plateau = 0;
            p_origin = w;
         end
         p_ack_tally = 1;
         p_reno = w;
      end
      t = $signed(now + p_min_delay - p_epoch);
      off = (t < $signed({32'd0, p_plateau})) ? $signed({32'd0, p_plateau}) - t
                                               : t - $signed({32'd0, p_plateau});
      d = cubic_growth(off);
      target = (t < $signed({32'd0, p_plateau})) ? $signed({32'd0, p_origin}) - d
                                                  : $signed({32'd0, p_origin}) + d;
      if (target > $signed({32'd0, w})) cnt = {32'd0, w} / (target - $signed({32'd0, w}));
      else cnt = {32'd0, w} * 100;
      p_acks_per_inc = sat_count(cnt);
      step = 32'(({32'd0, w} * 23) >> 3);
      if (step != 0 && p_ack_tally > step)
         p_reno = sat_window({32'd0, p_reno} + (p_ack_tally - 1) / step);
      p_ack_tally = 0;
      if (p_reno > w) begin
         mc = w / (p_reno - w);
         if (p_acks_per_inc > mc) p_acks_per_inc = mc;
      end
   endtask

   // Predict the window and threshold after one request.
   task automatic predict_window(logic cmd, logic [31:0] ack, logic [31:0] now,
                                 logic [15:0] srtt);
      window_pair_type pair;
      logic [31:0] w;
      if (cmd == EV_LOSS) begin
         w = p_window;
         p_epoch = 0;
         if (w < p_last_max) p_last_max = 32'(({32'd0, w} * BETA_FC) / 2048);
         else p_last_max = w;
         p_window = 32'(({32'd0, w} * BETA_NUM) / 1024);
         p_thresh = {1'b0, p_window[30:0]};
      end else begin
         if ($signed(ack) >= $signed(p_hs_end_seq)) begin
            p_hs_round_start = now;
            p_hs_last_ack = now;
            p_hs_prev_rtt = p_hs_round_rtt;
            p_hs_round_rtt = 0;
            p_hs_left = {24'd0, p_hs_samples};
            p_hs_end_seq = ack;
         end
         hystart_step(now, srtt);
         if (p_window <= p_thresh) begin
            p_window = sat_window({32'd0, p_window} + 1);
         end else begin
            cubic_step(now, srtt);
            if (p_inc_tally > p_acks_per_inc) begin
               p_window = sat_window({32'd0, p_window} + 1);
               p_inc_tally = 0;
            end else begin
               p_inc_tally = sat_count({32'd0, p_inc_tally} + 1);
            end
         end
      end
      pair.cwnd = p_window[23:0];
      pair.ssthresh = p_thresh[30:0];
      expected_windows.push_back(pair);
   endtask

   // Result side: random pops, checked against the oldest expectation.
   always @(negedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= pop_steady || ($urandom_range(99) >= pop_idle_pct);
   end

   always @(posedge clock) begin
      window_pair_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_windows.size() == 0) begin
            $error("unexpected response cwnd=%0d ssthresh=%0d", rsp_cwnd, rsp_ssthresh);
            error_count++;
         end else begin
            want = expected_windows.pop_front();
            if (rsp_cwnd !== want.cwnd) begin
               $error("cwnd expected %0d actual %0d", want.cwnd, rsp_cwnd);
               error_count++;
            end
            if (rsp_ssthresh !== want.ssthresh) begin
               $error("ssthresh expected %0d actual %0d", want.ssthresh, rsp_ssthresh);
               error_count++;
            end
         end
      end
   end

   // Send one request, with a random idle gap first unless push_steady is set. Push stays
   // high after the request is taken until the next idle gap or a drain lowers it.
   task automatic send_event(logic cmd, logic [31:0] ack, logic [31:0] now,
                             logic [15:0] srtt);
      if (!push_steady) begin
         while ($urandom_range(99) < 32) begin
            req_push <= 1'b0;
            @(negedge clock);
         end
      end
      req_push <= 1'b1;
      req_cmd <= cmd;
      req_ack_seq <= ack;
      req_now_ms <= now;
      req_smoothed_rtt <= srtt;
      do @(posedge clock); while (req_full);
      predict_window(cmd, ack, now, srtt);
      @(negedge clock);
   endtask

   // Wait for all responses, then a margin for the back engine to settle.
   task automatic drain_responses();
      req_push <= 1'b0;
      while (expected_windows.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_register(logic [1:0] index, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      apply_register(index, value);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Realistic flow: mostly rising acks with small time steps and some losses.
   task automatic send_flow(int count, ref logic [31:0] seq, ref logic [31:0] now);
      for (int i = 0; i < count; i++) begin
         seq = seq + $urandom_range(3000);
         now = now + $urandom_range(4);
         if ($urandom_range(99) < 6)
            send_event(EV_LOSS, $urandom, now, 16'($urandom_range(65535)));
         else if ($urandom_range(99) < 8)
            send_event(EV_ACK, $urandom, $urandom, 16'($urandom_range(65535)));
         else
            send_event(EV_ACK, seq, now, $urandom_range(99) < 5 ? 16'd0
                                                                 : 16'($urandom_range(10, 200)));
      end
   endtask

   // Directed: field extremes, both events, seq sign wrap, time wrap, zero rtt.
   task automatic test_directed();
      send_event(EV_ACK, 32'd0, 32'd0, 16'd0);
      send_event(EV_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_event(EV_ACK, 32'h7FFF_FFFF, 32'd1, 16'd1);
      send_event(EV_ACK, 32'h8000_0000, 32'd2, 16'd50);
      send_event(EV_LOSS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_event(EV_ACK, 32'd100, 32'd0, 16'd20);
      send_event(EV_ACK, 32'd200, 32'd0, 16'd20);
      send_event(EV_ACK, 32'd300, 32'hFFFF_FFF0, 16'd20);
      send_event(EV_ACK, 32'd400, 32'h0000_0010, 16'd0);
      send_event(EV_LOSS, 32'd0, 32'd20, 16'd0);
      send_event(EV_LOSS, 32'd0, 32'd21, 16'd0);
      for (int i = 0; i < 8; i++) send_event(EV_ACK, 32'd500 + i, 32'd30 + i, 16'd30);
      drain_responses();
   endtask

   // Extremes of the registers, including a saturated window.
   task automatic test_register_extremes();
      logic [31:0] seq, now;
      seq = 0;
      now = 5;
      write_register(CSR_INIT_WINDOW, 32'hFFFF_FFFF);
      write_register(CSR_INIT_THRESH, 32'd1);
      write_register(CSR_HS_SAMPLES, 32'd255);
      write_register(CSR_HS_LOW_WINDOW, 32'hFFFF_FFFF);
      send_flow(10, seq, now);
      drain_responses();
      write_register(CSR_INIT_WINDOW, 32'd1);
      write_register(CSR_INIT_THRESH, 32'hFFFF_FFFF);
      write_register(CSR_HS_SAMPLES, 32'd0);
      write_register(CSR_HS_LOW_WINDOW, 32'd0);
      send_flow(10, seq, now);
      drain_responses();
   endtask

   // Random phases, each with new register settings.
   task automatic test_random_phases();
      logic [31:0] seq, now;
      for (int phase = 0; phase < 12; phase++) begin
         write_register(CSR_INIT_WINDOW, $urandom_range(99) < 15 ? $urandom
                                                                 : $urandom_range(1, 400));
         write_register(CSR_INIT_THRESH, $urandom_range(99) < 30 ? 32'd0
                                                                 : $urandom_range(2, 300));
         write_register(CSR_HS_SAMPLES, $urandom_range(99) < 20 ? $urandom
                                                                : $urandom_range(0, 8));
         write_register(CSR_HS_LOW_WINDOW, $urandom_range(99) < 10 ? $urandom
                                                                   : $urandom_range(0, 64));
         seq = $urandom;
         now = $urandom;
         push_steady = (phase == 5);
         pop_steady = (phase == 5);
         pop_idle_pct = (phase == 8) ? 85 : 32;
         send_flow(100, seq, now);
         drain_responses();
      end
      push_steady = 1'b0;
      pop_steady = 1'b0;
      pop_idle_pct = 32;
   endtask

   initial begin
      reset_predictor();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_register_extremes();
      test_random_phases();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
